// ===== src/separable_smooth_gradient_laplacian_core_macros.svh =====
// Assertion macros for the separable smoothing core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SEPARABLE_SMOOTH_GRADIENT_LAPLACIAN_CORE_MACROS_SVH
`define SEPARABLE_SMOOTH_GRADIENT_LAPLACIAN_CORE_MACROS_SVH

// same-cycle implication
`define SSGL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSGL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ssgl_pkg.sv =====
// Shared types, codes and helpers for the separable smoothing core.
// No dependencies.
package ssgl_pkg;

    localparam int CW = 10;   // signed coordinate before folding
    localparam int PW = 11;   // fold period 2*(n-1)
    localparam int MW = 10;   // folded position
    localparam int DW = 9;    // image dimension register
    localparam int TW = 6;    // tap count register
    localparam int OW = 6;    // origin register
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 96;

    typedef enum logic [1:0] {
        ACT_TAP   = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_WIDTH   = 3'd0,
        CFG_HEIGHT  = 3'd1,
        CFG_TAPS0   = 3'd2,
        CFG_TAPS1   = 3'd3,
        CFG_TAPS2   = 3'd4,
        CFG_ORIGIN0 = 3'd5,
        CFG_ORIGIN1 = 3'd6,
        CFG_ORIGIN2 = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        KER_SMOOTH = 2'd0,
        KER_FIRST  = 2'd1,
        KER_SECOND = 2'd2,
        KER_NONE   = 2'd3
    } kernel_t;

    function automatic logic [MW-1:0] mirror_map(input logic [MW-1:0] m,
                                                 input logic [DW-1:0] n,
                                                 input logic [PW-1:0] p);
        logic [MW-1:0] r;
        if (p == '0)
            r = '0;
        else if (m >= MW'(n))
            r = MW'(p - PW'(m));
        else
            r = m;
        return r;
    endfunction

    function automatic logic [MW-1:0] mirror_step(input logic [MW-1:0] m,
                                                  input logic [PW-1:0] p);
        logic [MW-1:0] r;
        if (p == '0)
            r = '0;
        else if (PW'(m) + PW'(1) == p)
            r = '0;
        else
            r = m + MW'(1);
        return r;
    endfunction

    // vertical kernel of each pass: sm, grad a, grad b, lap a, lap b
    function automatic kernel_t pass_kv(input logic [2:0] pass);
        kernel_t k;
        case (pass)
            3'd2:    k = KER_FIRST;
            3'd4:    k = KER_SECOND;
            default: k = KER_SMOOTH;
        endcase
        return k;
    endfunction

    function automatic kernel_t pass_kh(input logic [2:0] pass);
        kernel_t k;
        case (pass)
            3'd1:    k = KER_FIRST;
            3'd3:    k = KER_SECOND;
            default: k = KER_SMOOTH;
        endcase
        return k;
    endfunction

endpackage

// ===== src/ssgl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssgl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/ssgl_mirror_div.sv =====
// Iterative remainder unit: folds a coordinate into one mirror period.
// Depends on ssgl_pkg. A start while busy restarts the fold.
module ssgl_mirror_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [ssgl_pkg::CW-1:0] coord,
    input  logic [ssgl_pkg::PW-1:0]      period,
    output logic                         done,
    output logic [ssgl_pkg::MW-1:0]      result
);
    import ssgl_pkg::*;

    localparam int VW = 18;

    logic [VW-1:0] v_reg, v_next;
    logic [2:0]    k_reg;
    logic          busy_reg, done_reg;
    logic [VW-1:0] shifted;

    assign shifted = VW'(period) << k_reg;

    always_comb
    begin
        v_next = v_reg;
        if (start)
            v_next = VW'(coord) + (VW'(period) << 5);
        else if (busy_reg && v_reg >= shifted)
            v_next = v_reg - shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 3'd7;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg - 3'd1;
                if (k_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign done   = done_reg;
    assign result = (period == '0) ? '0 : v_reg[MW-1:0];
endmodule

// ===== src/ssgl_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on ssgl_pkg. Returns floor root and remainder.
module ssgl_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root,
    output logic [32:0] rem
);
    import ssgl_pkg::*;

    logic [63:0] s_reg, r_reg, bit_reg;
    logic        busy_reg, done_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (s_reg >= trial)
            begin
                s_reg <= s_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];
    assign rem  = s_reg[32:0];
endmodule

// ===== src/separable_smooth_gradient_laplacian_core.sv =====
// Each query runs five kernel passes, nv by nh taps each, nv and nh being the vertical
// and horizontal tap counts of each pass, on the single shared multiply-accumulate unit
// fed by one image RAM read port. Tap and pixel writes go to their RAMs as they are
// accepted. Not ready while a query is in work.
// Reset (rst_n low, asynchronous) restores register defaults and idles the
// sequencer; image and kernel memories keep their contents.
module separable_smooth_gradient_laplacian_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_TAPS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // kernel_select, tap_index, tap_value, pix_x, pix_y, pixel_value
    input  logic [ssgl_pkg::IN_TDATA_W-1:0]     s_tdata,
    // action
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // smoothed, gradient_magnitude, laplacian_value
    output logic [ssgl_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [8:0]                          cfg_data
);
    import ssgl_pkg::*;

    `include "separable_smooth_gradient_laplacian_core_macros.svh"

    localparam int TB   = $clog2(MAX_TAPS + 1);
    localparam int HW   = 32 + TB;
    localparam int PRW  = 16 + HW;
    localparam int VW   = PRW + TB;
    localparam int RW   = VW + 1 - 15;
    localparam int IAW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int KD   = 3 * MAX_TAPS;
    localparam int KAW  = $clog2(KD);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_PSTART = 15'b000000000000010,
        ST_MOD    = 15'b000000000000100,
        ST_VTAP   = 15'b000000000001000,
        ST_VWAIT  = 15'b000000000010000,
        ST_HRUN   = 15'b000000000100000,
        ST_VMUL   = 15'b000000001000000,
        ST_VACC   = 15'b000000010000000,
        ST_PEND   = 15'b000000100000000,
        ST_RND    = 15'b000001000000000,
        ST_SQA    = 15'b000010000000000,
        ST_SQB    = 15'b000100000000000,
        ST_SQC    = 15'b001000000000000,
        ST_SQW    = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } state_t;

    // input fields
    logic [1:0]         in_ksel;
    logic [4:0]         in_tidx;
    logic [15:0]        in_tval;
    logic [7:0]         in_px, in_py;
    logic [15:0]        in_pval;
    logic               in_acc;

    assign in_ksel = s_tdata[1:0];
    assign in_tidx = s_tdata[6:2];
    assign in_tval = s_tdata[22:7];
    assign in_px   = s_tdata[30:23];
    assign in_py   = s_tdata[38:31];
    assign in_pval = s_tdata[54:39];
    assign in_acc  = s_tvalid && s_tready;

    // configuration
    logic [DW-1:0]        width_reg, height_reg;
    logic [TW-1:0]        taps_reg [3];
    logic signed [OW-1:0] origin_reg [3];

    state_t state_reg, state_next;
    logic [2:0]       pass_reg, pass_next;
    logic [TB-1:0]    i_reg, i_next, j_reg, j_next;
    logic [MW-1:0]    row_m_reg, row_m_next, col_m_reg, col_m_next;
    logic [MW-1:0]    col_start_reg, col_start_next;
    logic             v1_reg, v1_next, v2_reg, v2_next;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]              qx_reg, qx_next, qy_reg, qy_next;
    logic signed [15:0]      vtap_reg, vtap_next;
    logic signed [HW-1:0]    hacc_reg, hacc_next;
    logic signed [PRW-1:0]   prod_reg, prod_next;
    logic signed [VW-1:0]    vacc_reg, vacc_next;
    logic signed [VW-1:0]    sm_acc_reg, sm_acc_next, ga_acc_reg, ga_acc_next;
    logic signed [VW-1:0]    gb_acc_reg, gb_acc_next;
    logic signed [VW:0]      lp_acc_reg, lp_acc_next;
    logic [31:0]             sm_out_reg, sm_out_next, lp_out_reg, lp_out_next;
    logic [31:0]             ma_reg, ma_next, mb_reg, mb_next;
    logic [63:0]             sq_a_reg, sq_a_next, sq_b_reg, sq_b_next;
    logic [30:0]             grad_reg, grad_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    // derived geometry
    logic [DW-1:0]  w_eff, h_eff;
    logic [PW-1:0]  p_w, p_h;
    kernel_t        kv, kh;
    logic [TB-1:0]  nv, nh;
    logic signed [OW-1:0] org_v, org_h;
    logic [MW-1:0]  row_cur, col_cur;
    logic signed [CW-1:0] row_c0, col_c0;

    // memories
    logic               img_we, ker_we;
    logic [IAW-1:0]     img_waddr, img_raddr;
    logic [KAW-1:0]     ker_waddr, ker_raddr;
    logic [15:0]        img_rdata, ker_rdata;

    // shared units
    logic               mod_start, row_done, col_done;
    logic [MW-1:0]      row_res, col_res;
    logic               sqrt_start, sqrt_done;
    logic [31:0]        sqrt_root;
    logic [32:0]        sqrt_rem;
    logic [31:0]        sq_in;
    logic [63:0]        sq_out;
    logic signed [15:0] mul_a;
    logic signed [HW-1:0] mul_b;
    logic               issue;
    logic [32:0]        root_rnd;

    function automatic logic [TB-1:0] clamp_taps(input logic [TW-1:0] t);
        return (32'(t) > MAX_TAPS) ? TB'(MAX_TAPS) : TB'(t);
    endfunction

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d,
                                                input int unsigned lim);
        logic [DW-1:0] r;
        if (d == '0)
            r = DW'(1);
        else if (32'(d) > lim)
            r = DW'(lim);
        else
            r = d;
        return r;
    endfunction

    function automatic logic signed [RW-1:0] round15(input logic signed [VW:0] v);
        logic signed [VW:0] t;
        t = v + (VW+1)'(16384);
        return RW'(t >>> 15);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [RW-1:0] r);
        logic [31:0] o;
        if (r[RW-1:31] == {(RW-31){r[31]}})
            o = r[31:0];
        else if (r[RW-1])
            o = 32'h8000_0000;
        else
            o = 32'h7FFF_FFFF;
        return o;
    endfunction

    function automatic logic [31:0] capmag(input logic signed [RW-1:0] r);
        logic [RW-1:0] m;
        logic [31:0]   o;
        m = r[RW-1] ? RW'(-r) : RW'(r);
        if ((|m[RW-1:32]) || (m[31] && (|m[30:0])))
            o = 32'h8000_0000;
        else
            o = m[31:0];
        return o;
    endfunction

    assign w_eff = clamp_dim(width_reg, MAX_WIDTH);
    assign h_eff = clamp_dim(height_reg, MAX_HEIGHT);
    assign p_w   = PW'(w_eff - DW'(1)) << 1;
    assign p_h   = PW'(h_eff - DW'(1)) << 1;

    assign kv = pass_kv(pass_reg);
    assign kh = pass_kh(pass_reg);

    always_comb
    begin
        case (kv)
            KER_FIRST:
            begin
                nv    = clamp_taps(taps_reg[1]);
                org_v = origin_reg[1];
            end
            KER_SECOND:
            begin
                nv    = clamp_taps(taps_reg[2]);
                org_v = origin_reg[2];
            end
            default:
            begin
                nv    = clamp_taps(taps_reg[0]);
                org_v = origin_reg[0];
            end
        endcase
        case (kh)
            KER_FIRST:
            begin
                nh    = clamp_taps(taps_reg[1]);
                org_h = origin_reg[1];
            end
            KER_SECOND:
            begin
                nh    = clamp_taps(taps_reg[2]);
                org_h = origin_reg[2];
            end
            default:
            begin
                nh    = clamp_taps(taps_reg[0]);
                org_h = origin_reg[0];
            end
        endcase
    end

    assign row_c0  = signed'({2'b00, qy_reg}) + CW'(org_v);
    assign col_c0  = signed'({2'b00, qx_reg}) + CW'(org_h);
    assign row_cur = mirror_map(row_m_reg, h_eff, p_h);
    assign col_cur = mirror_map(col_m_reg, w_eff, p_w);

    assign issue = (state_reg == ST_HRUN) && (i_reg < nh);

    // memory ports
    assign img_we    = in_acc && (s_tuser == ACT_PIXEL) &&
                       (32'(in_px) < MAX_WIDTH) && (32'(in_py) < MAX_HEIGHT);
    assign img_waddr = IAW'(in_py) * IAW'(MAX_WIDTH) + IAW'(in_px);
    assign img_raddr = IAW'(row_cur) * IAW'(MAX_WIDTH) + IAW'(col_cur);
    assign ker_we    = in_acc && (s_tuser == ACT_TAP) && (in_ksel != KER_NONE) &&
                       (32'(in_tidx) < MAX_TAPS);
    assign ker_waddr = KAW'(in_ksel) * KAW'(MAX_TAPS) + KAW'(in_tidx);
    assign ker_raddr = (state_reg == ST_VTAP) ?
                       KAW'(kv) * KAW'(MAX_TAPS) + KAW'(j_reg) :
                       KAW'(kh) * KAW'(MAX_TAPS) + KAW'(i_reg);

    ssgl_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_img_ram (
        .clk   (clk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (in_pval),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    ssgl_ram #(.WIDTH(16), .DEPTH(KD)) u_ker_ram (
        .clk   (clk),
        .we    (ker_we),
        .waddr (ker_waddr),
        .wdata (in_tval),
        .raddr (ker_raddr),
        .rdata (ker_rdata)
    );

    assign mod_start = (state_reg == ST_PSTART);

    ssgl_mirror_div u_row_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .coord  (row_c0),
        .period (p_h),
        .done   (row_done),
        .result (row_res)
    );

    ssgl_mirror_div u_col_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .coord  (col_c0),
        .period (p_w),
        .done   (col_done),
        .result (col_res)
    );

    assign sqrt_start = (state_reg == ST_SQC);

    ssgl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_a_reg + sq_b_reg),
        .done     (sqrt_done),
        .root     (sqrt_root),
        .rem      (sqrt_rem)
    );

    assign mul_a    = (state_reg == ST_VMUL) ? vtap_reg : signed'(ker_rdata);
    assign mul_b    = (state_reg == ST_VMUL) ? hacc_reg : HW'(signed'(img_rdata));
    assign sq_in    = (state_reg == ST_SQA) ? ma_reg : mb_reg;
    assign sq_out   = 64'(sq_in) * 64'(sq_in);
    assign root_rnd = 33'(sqrt_root) + ((33'(sqrt_rem) > 33'(sqrt_root)) ? 33'd1 : 33'd0);

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        row_m_next     = row_m_reg;
        col_m_next     = col_m_reg;
        col_start_next = col_start_reg;
        v1_next        = 1'b0;
        v2_next        = v1_reg;
        out_valid_next = out_valid_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        vtap_next      = vtap_reg;
        hacc_next      = hacc_reg;
        prod_next      = prod_reg;
        vacc_next      = vacc_reg;
        sm_acc_next    = sm_acc_reg;
        ga_acc_next    = ga_acc_reg;
        gb_acc_next    = gb_acc_reg;
        lp_acc_next    = lp_acc_reg;
        sm_out_next    = sm_out_reg;
        lp_out_next    = lp_out_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        sq_a_next      = sq_a_reg;
        sq_b_next      = sq_b_reg;
        grad_next      = grad_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_tuser == ACT_QUERY)
                begin
                    qx_next    = in_px;
                    qy_next    = in_py;
                    pass_next  = '0;
                    state_next = ST_PSTART;
                end
            end
            ST_PSTART:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (row_done && col_done)
                begin
                    row_m_next     = row_res;
                    col_start_next = col_res;
                    vacc_next      = '0;
                    j_next         = '0;
                    state_next     = (nv == '0) ? ST_PEND : ST_VTAP;
                end
            end
            ST_VTAP:
            begin
                state_next = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                vtap_next  = signed'(ker_rdata);
                hacc_next  = '0;
                i_next     = '0;
                col_m_next = col_start_reg;
                state_next = ST_HRUN;
            end
            ST_HRUN:
            begin
                v1_next = issue;
                if (issue)
                begin
                    i_next     = i_reg + TB'(1);
                    col_m_next = mirror_step(col_m_reg, p_w);
                end
                if (v1_reg)
                    prod_next = PRW'(mul_a * mul_b);
                if (v2_reg)
                    hacc_next = hacc_reg + HW'(prod_reg);
                if (!issue && !v1_reg && !v2_reg)
                    state_next = ST_VMUL;
            end
            ST_VMUL:
            begin
                prod_next  = PRW'(mul_a * mul_b);
                state_next = ST_VACC;
            end
            ST_VACC:
            begin
                vacc_next  = vacc_reg + VW'(prod_reg);
                j_next     = j_reg + TB'(1);
                row_m_next = mirror_step(row_m_reg, p_h);
                state_next = (j_reg + TB'(1) < nv) ? ST_VTAP : ST_PEND;
            end
            ST_PEND:
            begin
                case (pass_reg)
                    3'd0:    sm_acc_next = vacc_reg;
                    3'd1:    ga_acc_next = vacc_reg;
                    3'd2:    gb_acc_next = vacc_reg;
                    3'd3:    lp_acc_next = (VW+1)'(vacc_reg);
                    default: lp_acc_next = lp_acc_reg + (VW+1)'(vacc_reg);
                endcase
                if (pass_reg == 3'd4)
                    state_next = ST_RND;
                else
                begin
                    pass_next  = pass_reg + 3'd1;
                    state_next = ST_PSTART;
                end
            end
            ST_RND:
            begin
                sm_out_next = sat32(round15((VW+1)'(sm_acc_reg)));
                lp_out_next = sat32(round15(lp_acc_reg));
                ma_next     = capmag(round15((VW+1)'(ga_acc_reg)));
                mb_next     = capmag(round15((VW+1)'(gb_acc_reg)));
                state_next  = ST_SQA;
            end
            ST_SQA:
            begin
                sq_a_next  = sq_out;
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                sq_b_next  = sq_out;
                state_next = ST_SQC;
            end
            ST_SQC:
            begin
                state_next = ST_SQW;
            end
            ST_SQW:
            begin
                if (sqrt_done)
                begin
                    grad_next  = (root_rnd > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF :
                                 root_rnd[30:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {1'b0, lp_out_reg, grad_reg, sm_out_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= DW'(256);
            height_reg    <= DW'(256);
            taps_reg[0]   <= TW'(1);
            taps_reg[1]   <= TW'(1);
            taps_reg[2]   <= TW'(1);
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:   width_reg     <= cfg_data;
                    CFG_HEIGHT:  height_reg    <= cfg_data;
                    CFG_TAPS0:   taps_reg[0]   <= cfg_data[TW-1:0];
                    CFG_TAPS1:   taps_reg[1]   <= cfg_data[TW-1:0];
                    CFG_TAPS2:   taps_reg[2]   <= cfg_data[TW-1:0];
                    CFG_ORIGIN0: origin_reg[0] <= signed'(cfg_data[OW-1:0]);
                    CFG_ORIGIN1: origin_reg[1] <= signed'(cfg_data[OW-1:0]);
                    CFG_ORIGIN2: origin_reg[2] <= signed'(cfg_data[OW-1:0]);
                    default:     width_reg     <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_m_reg     <= row_m_next;
        col_m_reg     <= col_m_next;
        col_start_reg <= col_start_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        vtap_reg      <= vtap_next;
        hacc_reg      <= hacc_next;
        prod_reg      <= prod_next;
        vacc_reg      <= vacc_next;
        sm_acc_reg    <= sm_acc_next;
        ga_acc_reg    <= ga_acc_next;
        gb_acc_reg    <= gb_acc_next;
        lp_acc_reg    <= lp_acc_next;
        sm_out_reg    <= sm_out_next;
        lp_out_reg    <= lp_out_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        sq_a_reg      <= sq_a_next;
        sq_b_reg      <= sq_b_next;
        grad_reg      <= grad_next;
        out_data_reg  <= out_data_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    `SSGL_ASSERT_NXT(a_query_busy, in_acc && s_tuser == ACT_QUERY, !s_tready,
                     "query request did not stall the input")
    `SSGL_ASSERT_IMP(a_sqrt_done_state, sqrt_done, state_reg == ST_SQW,
                     "root finished outside its wait state")
    `SSGL_ASSERT_IMP(a_result_source, $rose(m_tvalid), $past(state_reg == ST_OUT),
                     "result appeared without a finished query")
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for separable_smooth_gradient_laplacian_core.
// Predicts smoothed, gradient and Laplacian results per query in a scoreboard
// class; depends on ssgl_pkg and the core RTL only.
`timescale 1ns / 1ps

import ssgl_pkg::*;

class filter_scoreboard;
    shortint img[65536];
    bit      img_set[65536];
    shortint ker[96];
    int      dim_w, dim_h;
    int      ntap[3];
    int      org[3];
    logic [94:0] result_q[$];
    int      mismatches;
    int      queries_seen;
    int      results_checked;

    function new();
        dim_w = 256;
        dim_h = 256;
        for (int k = 0; k < 3; k++)
        begin
            ntap[k] = 1;
            org[k] = 0;
        end
        mismatches = 0;
        queries_seen = 0;
        results_checked = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [8:0] val);
        case (idx)
            CFG_WIDTH:   dim_w = int'(val);
            CFG_HEIGHT:  dim_h = int'(val);
            CFG_TAPS0:   ntap[0] = int'(val[5:0]);
            CFG_TAPS1:   ntap[1] = int'(val[5:0]);
            CFG_TAPS2:   ntap[2] = int'(val[5:0]);
            CFG_ORIGIN0: org[0] = $signed(val[5:0]);
            CFG_ORIGIN1: org[1] = $signed(val[5:0]);
            CFG_ORIGIN2: org[2] = $signed(val[5:0]);
            default: ;
        endcase
    endfunction

    function int clamp_dim(int v);
        if (v == 0)
            return 1;
        return (v > 256) ? 256 : v;
    endfunction

    function int taps(int k);
        return (ntap[k] > 32) ? 32 : ntap[k];
    endfunction

    function int fold(int c, int n);
        int p;
        int m;
        if (n <= 1)
            return 0;
        p = 2 * (n - 1);
        m = ((c % p) + p) % p;
        if (m >= n)
            m = p - m;
        return m;
    endfunction

    function longint row_sum(int k, int x, int r);
        int row;
        longint acc;
        row = fold(r, clamp_dim(dim_h));
        acc = 0;
        for (int i = 0; i < taps(k); i++)
            acc += longint'(ker[k * 32 + i]) *
                   longint'(img[row * 256 + fold(x + org[k] + i, clamp_dim(dim_w))]);
        return acc;
    endfunction

    function longint col_sum(int kv, int kh, int x, int y);
        longint acc;
        acc = 0;
        for (int j = 0; j < taps(kv); j++)
            acc += longint'(ker[kv * 32 + j]) * row_sum(kh, x, y + org[kv] + j);
        return acc;
    endfunction

    function longint round15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function longint unsigned cap_mag(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        return (m > 64'd2147483648) ? 64'd2147483648 : m;
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // unwritten pixels that a query at (x,y) would read
    function void unwritten_reads(int x, int y, output int addr_q[$]);
        int rows[$];
        int cols[$];
        int a;
        addr_q.delete();
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < taps(k); i++)
            begin
                rows.push_back(fold(y + org[k] + i, clamp_dim(dim_h)));
                cols.push_back(fold(x + org[k] + i, clamp_dim(dim_w)));
            end
        rows = rows.unique();
        cols = cols.unique();
        foreach (rows[r])
            foreach (cols[c])
            begin
                a = rows[r] * 256 + cols[c];
                if (!img_set[a])
                begin
                    img_set[a] = 1;
                    addr_q.push_back(a);
                end
            end
    endfunction

    function void note_request(action_t act, logic [55:0] d);
        kernel_t ks;
        int x;
        int y;
        longint sm;
        longint ga;
        longint gb;
        longint lp;
        longint unsigned s;
        longint unsigned r;
        ks = kernel_t'(d[1:0]);
        x = int'(d[30:23]);
        y = int'(d[38:31]);
        case (act)
            ACT_TAP:
                if (ks != KER_NONE)
                    ker[int'(ks) * 32 + int'(d[6:2])] = d[22:7];
            ACT_PIXEL:
            begin
                img[y * 256 + x] = d[54:39];
                img_set[y * 256 + x] = 1;
            end
            ACT_QUERY:
            begin
                sm = round15(col_sum(0, 0, x, y));
                ga = round15(col_sum(0, 1, x, y));
                gb = round15(col_sum(1, 0, x, y));
                lp = round15(col_sum(0, 2, x, y) + col_sum(2, 0, x, y));
                s = cap_mag(ga) * cap_mag(ga) + cap_mag(gb) * cap_mag(gb);
                r = int_sqrt(s);
                if (s - r * r > r)
                    r++;
                if (r > 64'h7FFFFFFF)
                    r = 64'h7FFFFFFF;
                result_q.push_back({sat32(lp), r[30:0], sat32(sm)});
                queries_seen++;
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [95:0] d);
        logic [94:0] e;
        if (result_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", d);
            return;
        end
        e = result_q.pop_front();
        results_checked++;
        if (d[31:0] !== e[31:0] || d[62:32] !== e[62:32] || d[94:63] !== e[94:63])
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: smoothed %0d/%0d gradient %0d/%0d laplacian %0d/%0d",
                         $signed(e[31:0]), $signed(d[31:0]), e[62:32], d[62:32],
                         $signed(e[94:63]), $signed(d[94:63]));
        end
    endfunction
endclass

module testbench;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;

    filter_scoreboard sb;
    int burst_left;
    int cycle_count;
    int phases_run;

    separable_smooth_gradient_laplacian_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 4000000)
            begin
                $display("timeout waiting for results");
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver: changing stall pattern, one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int held;
        mode = 0;
        mode_left = 0;
        held = 0;
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (held == 0 && sb.results_checked == 1)
            begin
                held = 1;
                m_tready <= 0;
                repeat (4000) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 400);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send(action_t act, kernel_t ks, logic [4:0] ti, logic [15:0] tv,
                        logic [7:0] px, logic [7:0] py, logic [15:0] pv);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, pv, py, px, tv, ti, ks};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(act, {1'b0, pv, py, px, tv, ti, ks});
    endtask

    task automatic write_tap(kernel_t ks, int idx, logic [15:0] v);
        send(ACT_TAP, ks, 5'(idx), v, 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic write_pixel(int x, int y, logic [15:0] v);
        send(ACT_PIXEL, kernel_t'($urandom_range(0, 3)), 5'($urandom), 16'($urandom),
             8'(x), 8'(y), v);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // fill whatever the query would read that was never written, then query
    task automatic query(int x, int y);
        int fill_q[$];
        sb.unwritten_reads(x, y, fill_q);
        foreach (fill_q[i])
            write_pixel(fill_q[i] % 256, fill_q[i] / 256, rand_sample());
        send(ACT_QUERY, kernel_t'($urandom_range(0, 3)), 5'($urandom), 16'($urandom),
             8'(x), 8'(y), 16'($urandom));
    endtask

    task automatic write_reg(cfg_index_t idx, int val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= 9'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, 9'(val));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        while (sb.result_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic configure(int w, int h, int t0, int t1, int t2, int o0, int o1, int o2);
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_TAPS0, t0);
        write_reg(CFG_TAPS1, t1);
        write_reg(CFG_TAPS2, t2);
        write_reg(CFG_ORIGIN0, o0 & 63);
        write_reg(CFG_ORIGIN1, o1 & 63);
        write_reg(CFG_ORIGIN2, o2 & 63);
        cfg_valid <= 0;
        phases_run++;
    endtask

    task automatic load_kernels();
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 32; i++)
                write_tap(kernel_t'(k), i, rand_sample());
    endtask

    task automatic random_mix(int count, int w, int h);
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                query($urandom_range(0, w - 1), $urandom_range(0, h - 1));
            else if (sel < 50)
                query($urandom_range(0, 255), $urandom_range(0, 255));
            else if (sel < 82)
                write_pixel($urandom_range(0, 255), $urandom_range(0, 255), rand_sample());
            else if (sel < 95)
                write_tap(kernel_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                          rand_sample());
            else
                send(ACT_NONE, kernel_t'($urandom_range(0, 3)), 5'($urandom),
                     16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        int w;
        int h;
        sb = new();
        burst_left = 0;
        phases_run = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = ACT_NONE;
        cfg_valid = 0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        load_kernels();
        write_tap(KER_NONE, 31, 16'h1234);
        send(ACT_NONE, KER_SMOOTH, 5'd0, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
        write_pixel(0, 0, 16'h8000);
        write_pixel(255, 255, 16'h7FFF);
        query(0, 0);
        query(255, 255);
        query(255, 0);
        query(0, 255);

        configure(256, 256, 3, 3, 3, -31, 31, -32);
        query(0, 0);
        query(255, 255);
        query(3, 250);

        configure(2, 2, 32, 32, 32, 0, -16, 5);
        for (int i = 0; i < 32; i++)
        begin
            write_tap(KER_SMOOTH, i, 16'h8000);
            write_tap(KER_FIRST, i, 16'h7FFF);
            write_tap(KER_SECOND, i, 16'h8000);
        end
        for (int i = 0; i < 4; i++)
            write_pixel(i % 2, i / 2, 16'h8000);
        query(0, 0);
        query(1, 1);

        configure(1, 1, 1, 2, 1, 7, -7, 0);
        load_kernels();
        query(0, 0);
        query(200, 100);

        configure(0, 300, 63, 0, 40, 31, -31, 12);
        query(17, 9);
        query(255, 0);

        configure(4, 3, 32, 17, 32, -20, 3, 31);
        random_mix(6, 4, 3);

        for (int p = 0; p < 4; p++)
        begin
            case ($urandom_range(0, 3))
                0: w = 1;
                default: w = $urandom_range(2, 8);
            endcase
            h = $urandom_range(1, 8);
            configure(w, h, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                      $urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32,
                      $urandom_range(0, 63) - 32);
            random_mix(10, w, h);
        end

        drain();
        $display("ran %0d register settings, %0d queries, %0d results checked",
                 phases_run, sb.queries_seen, sb.results_checked);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
